// ----- rtl/evt_tmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer package
// Register offsets, bit positions, operation codes and reset values shared by
// the single-comparator event timer.
// ----------------------------------------------------------------------------
package evt_tmr_pkg;

    // Operation carried with each input transaction.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Byte offsets of the 64-bit timer registers.
    localparam logic [8:0] OFS_ID       = 9'h000;
    localparam logic [8:0] OFS_GCONFIG  = 9'h010;
    localparam logic [8:0] OFS_STATUS   = 9'h020;
    localparam logic [8:0] OFS_COUNTER  = 9'h0F0;
    localparam logic [8:0] OFS_T0CONFIG = 9'h100;
    localparam logic [8:0] OFS_T0COMP   = 9'h108;
    localparam logic [8:0] OFS_T0ROUTE  = 9'h110;

    // Bit positions within the configuration registers.
    localparam int BIT_CNT_EN    = 0;
    localparam int BIT_LEG_RT    = 1;
    localparam int BIT_STATUS    = 0;
    localparam int BIT_T_INT_EN  = 2;
    localparam int BIT_T_MSG_EN  = 14;
    localparam int BIT_T_MSG_CAP = 15;

    // Field widths.
    localparam int PERIOD_W  = 27;
    localparam int OFFSET_W  = 9;
    localparam int DATA_W    = 64;
    localparam int MADDR_W   = 32;
    localparam int MDATA_W   = 16;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 120;

    // Configuration port indexes (word addresses).
    typedef enum logic {
        CFG_PERIOD = 1'b0,
        CFG_MSGCAP = 1'b1
    } cfg_idx_t;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 27'd69841279;

endpackage

// ----- rtl/event_timer_single_comparator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer with one comparator
// Main counter, comparator and message route behind a 64-bit register map,
// driven by a stream of tick, read and write transactions.
// ----------------------------------------------------------------------------
// Each input transaction is a clock tick, a register read or a register write;
// each one yields exactly one result transaction. While the result side keeps
// taking them, the block takes one transaction per cycle: an input register
// feeds a single pass of logic (one 64-bit increment and compare against the
// comparator) that updates the timer state and loads the result register. A
// result is offered once its transaction has passed the input register and
// been loaded into the result register; when the result side stalls, the
// two registers fill and the input side stalls with it. The APB port sets
// the reported tick period (address 0) and the message-capable bit (address 4)
// and should be written only while no transaction is in flight.
module event_timer_single_comparator
    import evt_tmr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [8:0] offset, [72:9] write_data, zero pad
    input  logic [1:0]            s_tuser,   // [1:0] operation

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [63:0] read_data, [64] legacy_irq,
                                             // [65] message_fire, [97:66] message_address,
                                             // [113:98] message_data, zero pad

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Configuration registers.
    logic [PERIOD_W-1:0] period_reg;
    logic                msg_cap_reg;

    // Timer state.
    logic [DATA_W-1:0]   counter_reg,    counter_next;
    logic                cnt_en_reg,     cnt_en_next;
    logic                leg_rt_reg,     leg_rt_next;
    logic                status_reg,     status_next;
    logic                int_en_reg,     int_en_next;
    logic                msg_en_reg,     msg_en_next;
    logic [DATA_W-1:0]   comp_reg,       comp_next;
    logic [DATA_W-1:0]   route_reg,      route_next;

    // Input register.
    logic                in_vld_reg;
    op_t                 in_op_reg;
    logic [OFFSET_W-1:0] in_ofs_reg;
    logic [DATA_W-1:0]   in_wd_reg;

    // Result register.
    logic                out_vld_reg;
    logic [DATA_W-1:0]   rd_reg,         rd_next;
    logic                leg_irq_reg,    leg_irq_next;
    logic                msg_fire_reg,   msg_fire_next;
    logic [MADDR_W-1:0]  maddr_reg,      maddr_next;
    logic [MDATA_W-1:0]  mdata_reg,      mdata_next;

    logic                out_free;
    logic                advance;
    logic                cfg_wr;
    logic [DATA_W-1:0]   cnt_inc;
    logic                cfg_idx;

    // Handshake: the input register moves on whenever the result register is free.
    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_comb begin
        prdata = '0;
        case (cfg_idx_t'(cfg_idx))
            CFG_PERIOD: prdata = {{(32-PERIOD_W){1'b0}}, period_reg};
            CFG_MSGCAP: prdata = {31'd0, msg_cap_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= PERIOD_RESET;
            msg_cap_reg <= 1'b1;
        end else if (cfg_wr) begin
            if (cfg_idx_t'(cfg_idx) == CFG_PERIOD) begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end else begin
                msg_cap_reg <= pwdata[0];
            end
        end
    end

    // Input register: capture each accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg  <= op_t'(s_tuser);
            in_ofs_reg <= s_tdata[OFFSET_W-1:0];
            in_wd_reg  <= s_tdata[OFFSET_W+DATA_W-1:OFFSET_W];
        end
    end

    assign cnt_inc = counter_reg + 64'd1;

    // Single pass: state update and result for the transaction in the input register.
    always_comb begin
        counter_next  = counter_reg;
        cnt_en_next   = cnt_en_reg;
        leg_rt_next   = leg_rt_reg;
        status_next   = status_reg;
        int_en_next   = int_en_reg;
        msg_en_next   = msg_en_reg;
        comp_next     = comp_reg;
        route_next    = route_reg;
        rd_next       = '0;
        leg_irq_next  = 1'b0;
        msg_fire_next = 1'b0;
        maddr_next    = '0;
        mdata_next    = '0;

        case (in_op_reg)
            OP_TICK: begin
                if (cnt_en_reg) begin
                    counter_next = cnt_inc;
                    if (cnt_inc == comp_reg && int_en_reg) begin
                        status_next = 1'b1;
                        if (msg_en_reg && msg_cap_reg) begin
                            msg_fire_next = 1'b1;
                            maddr_next    = route_reg[DATA_W-1:DATA_W-MADDR_W];
                            mdata_next    = route_reg[MDATA_W-1:0];
                        end else begin
                            leg_irq_next = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (in_ofs_reg)
                    OFS_ID:       rd_next = {{(32-PERIOD_W){1'b0}}, period_reg, 32'd0};
                    OFS_GCONFIG: begin
                        rd_next[BIT_CNT_EN] = cnt_en_reg;
                        rd_next[BIT_LEG_RT] = leg_rt_reg;
                    end
                    OFS_STATUS:   rd_next[BIT_STATUS] = status_reg;
                    OFS_COUNTER:  rd_next = counter_reg;
                    OFS_T0CONFIG: begin
                        rd_next[BIT_T_INT_EN]  = int_en_reg;
                        rd_next[BIT_T_MSG_EN]  = msg_en_reg;
                        rd_next[BIT_T_MSG_CAP] = msg_cap_reg;
                    end
                    OFS_T0COMP:   rd_next = comp_reg;
                    OFS_T0ROUTE:  rd_next = route_reg;
                    default:      rd_next = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (in_ofs_reg)
                    OFS_GCONFIG: begin
                        cnt_en_next = in_wd_reg[BIT_CNT_EN];
                        leg_rt_next = in_wd_reg[BIT_LEG_RT];
                    end
                    OFS_STATUS: begin
                        // Write one to clear.
                        if (in_wd_reg[BIT_STATUS]) begin
                            status_next = 1'b0;
                        end
                    end
                    OFS_COUNTER:  counter_next = in_wd_reg;
                    OFS_T0CONFIG: begin
                        int_en_next = in_wd_reg[BIT_T_INT_EN];
                        msg_en_next = in_wd_reg[BIT_T_MSG_EN];
                    end
                    OFS_T0COMP:   comp_next  = in_wd_reg;
                    OFS_T0ROUTE:  route_next = in_wd_reg;
                    default:      ;
                endcase
            end
            default: ;
        endcase
    end

    // Timer state commits as the transaction moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            cnt_en_reg  <= 1'b0;
            leg_rt_reg  <= 1'b0;
            status_reg  <= 1'b0;
            int_en_reg  <= 1'b0;
            msg_en_reg  <= 1'b0;
            comp_reg    <= '1;
            route_reg   <= '0;
        end else if (advance) begin
            counter_reg <= counter_next;
            cnt_en_reg  <= cnt_en_next;
            leg_rt_reg  <= leg_rt_next;
            status_reg  <= status_next;
            int_en_reg  <= int_en_next;
            msg_en_reg  <= msg_en_next;
            comp_reg    <= comp_next;
            route_reg   <= route_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_reg       <= rd_next;
            leg_irq_reg  <= leg_irq_next;
            msg_fire_reg <= msg_fire_next;
            maddr_reg    <= maddr_next;
            mdata_reg    <= mdata_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-DATA_W-2-MADDR_W-MDATA_W){1'b0}},
                       mdata_reg, maddr_reg, msg_fire_reg, leg_irq_reg, rd_reg};

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer testbench
// Drives tick, read and write transactions into the single-comparator event
// timer, predicts every result from its own copy of the timer state and
// checks each result transaction field by field, over several settings of the
// tick period and the message-capable bit.
// ----------------------------------------------------------------------------
module tb
    import evt_tmr_pkg::*;
;

    // Fields of one result transaction.
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               legacy_irq;
        logic               message_fire;
        logic [MADDR_W-1:0] message_address;
        logic [MDATA_W-1:0] message_data;
    } timer_result_t;

    // Timer state mirror and the queue of results still to arrive.
    class timer_scoreboard;
        logic [PERIOD_W-1:0] period_fs;
        logic                msg_cap;
        logic [DATA_W-1:0]   count;
        logic [DATA_W-1:0]   comp;
        logic [DATA_W-1:0]   route;
        logic                cnt_en;
        logic                leg_rt;
        logic                status;
        logic                int_en;
        logic                msg_en;
        timer_result_t       pending_results[$];
        int                  errors;

        function new();
            period_fs = PERIOD_RESET;
            msg_cap   = 1'b1;
            count     = '0;
            comp      = '1;
            route     = '0;
            cnt_en    = 1'b0;
            leg_rt    = 1'b0;
            status    = 1'b0;
            int_en    = 1'b0;
            msg_en    = 1'b0;
            errors    = 0;
        endfunction

        // Register contents as seen by a read; unmapped offsets read zero.
        function logic [DATA_W-1:0] reg_value(logic [OFFSET_W-1:0] ofs);
            logic [DATA_W-1:0] v;
            v = '0;
            case (ofs)
                OFS_ID:       v[63:32] = {5'd0, period_fs};
                OFS_GCONFIG: begin
                    v[BIT_CNT_EN] = cnt_en;
                    v[BIT_LEG_RT] = leg_rt;
                end
                OFS_STATUS:   v[BIT_STATUS] = status;
                OFS_COUNTER:  v = count;
                OFS_T0CONFIG: begin
                    v[BIT_T_INT_EN]  = int_en;
                    v[BIT_T_MSG_EN]  = msg_en;
                    v[BIT_T_MSG_CAP] = msg_cap;
                end
                OFS_T0COMP:   v = comp;
                OFS_T0ROUTE:  v = route;
                default: ;
            endcase
            return v;
        endfunction

        // Apply one accepted input transaction and queue the result it yields.
        function void note_input(op_t op, logic [OFFSET_W-1:0] ofs, logic [DATA_W-1:0] wd);
            timer_result_t r;
            r = '0;
            case (op)
                OP_TICK: begin
                    if (cnt_en) begin
                        count = count + 64'd1;
                        if (count == comp && int_en) begin
                            status = 1'b1;
                            if (msg_en && msg_cap) begin
                                r.message_fire    = 1'b1;
                                r.message_address = route[63:32];
                                r.message_data    = route[15:0];
                            end else begin
                                r.legacy_irq = 1'b1;
                            end
                        end
                    end
                end
                OP_READ: r.read_data = reg_value(ofs);
                OP_WRITE: begin
                    case (ofs)
                        OFS_GCONFIG: begin
                            cnt_en = wd[BIT_CNT_EN];
                            leg_rt = wd[BIT_LEG_RT];
                        end
                        OFS_STATUS: begin
                            if (wd[BIT_STATUS])
                                status = 1'b0;
                        end
                        OFS_COUNTER: count = wd;
                        OFS_T0CONFIG: begin
                            int_en = wd[BIT_T_INT_EN];
                            msg_en = wd[BIT_T_MSG_EN];
                        end
                        OFS_T0COMP:  comp = wd;
                        OFS_T0ROUTE: route = wd;
                        default: ;
                    endcase
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("tb: mismatch at %0t ns: %s", $time, what);
        endtask

        // Compare one result transaction with the oldest expectation.
        task check_result(logic [M_TDATA_W-1:0] t);
            timer_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h with nothing expected", t));
                return;
            end
            want = pending_results.pop_front();
            if (t[63:0] !== want.read_data)
                report($sformatf("read_data %h, expected %h", t[63:0], want.read_data));
            if (t[64] !== want.legacy_irq)
                report($sformatf("legacy_irq %b, expected %b", t[64], want.legacy_irq));
            if (t[65] !== want.message_fire)
                report($sformatf("message_fire %b, expected %b", t[65], want.message_fire));
            if (t[97:66] !== want.message_address)
                report($sformatf("message_address %h, expected %h", t[97:66],
                                 want.message_address));
            if (t[113:98] !== want.message_data)
                report($sformatf("message_data %h, expected %h", t[113:98],
                                 want.message_data));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [8:0] offset, [72:9] write_data, zero pad
    logic [1:0]           s_tuser;   // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [63:0] read_data, [64] legacy_irq, [65] message_fire,
                                     // [97:66] message_address, [113:98] message_data
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    timer_scoreboard board = new();

    int items_sent    = 0;
    int burst_left    = 0;
    bit steady        = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;

    event_timer_single_comparator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watch both channels; inputs are noted before results are checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_input(op_t'(s_tuser), s_tdata[8:0], s_tdata[72:9]);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // Result side back-pressure: random patterns, plus a long hold-off on request.
    initial begin
        int rx_mode;
        int rx_left;
        m_tready = 1'b0;
        rx_mode  = 0;
        rx_left  = 0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                m_tready <= 1'b0;
                repeat (64) @(posedge aclk);
                holds_done++;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(8, 80);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly mapped offsets, otherwise anything in the 9-bit range.
    function automatic logic [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 9))
            0:       return OFS_ID;
            1:       return OFS_GCONFIG;
            2:       return OFS_STATUS;
            3:       return OFS_COUNTER;
            4:       return OFS_T0CONFIG;
            5:       return OFS_T0COMP;
            6:       return OFS_T0ROUTE;
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    // Offer one transaction and wait for it to be taken; gaps fall between bursts.
    task automatic send_item(op_t op, logic [OFFSET_W-1:0] ofs, logic [DATA_W-1:0] wd);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, wd, ofs};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (steady)
                gap = 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Stop offering and let every outstanding result drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle, then an idle cycle; pready is always high.
    task automatic apb_write(cfg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_PERIOD)
            board.period_fs = val[PERIOD_W-1:0];
        else
            board.msg_cap = val[0];
        @(posedge aclk);
    endtask

    // Random traffic: mostly complete arm-and-fire sequences, the rest noise.
    task automatic run_random(int n);
        int                stop_at;
        int                k;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] d;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 6) begin
                if ($urandom_range(0, 4) == 0)
                    v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 6));
                else
                    v = rand64();
                k = $urandom_range(1, 8);
                send_item(OP_WRITE, OFS_GCONFIG, rand64() | 64'h1);
                d = rand64();
                if ($urandom_range(0, 4) != 0)
                    d[BIT_T_INT_EN] = 1'b1;
                send_item(OP_WRITE, OFS_T0CONFIG, d);
                send_item(OP_WRITE, OFS_T0ROUTE, rand64());
                send_item(OP_WRITE, OFS_COUNTER, v);
                send_item(OP_WRITE, OFS_T0COMP, v + 64'(k));
                repeat (k + $urandom_range(0, 2)) begin
                    if ($urandom_range(0, 5) == 0)
                        send_item(OP_READ, pick_offset(), rand64());
                    send_item(OP_TICK, 9'($urandom_range(0, 511)), rand64());
                end
                send_item(OP_READ, OFS_STATUS, rand64());
                d = rand64();
                if ($urandom_range(0, 3) != 0)
                    d[BIT_STATUS] = 1'b1;
                send_item(OP_WRITE, OFS_STATUS, d);
                send_item(OP_READ, OFS_STATUS, rand64());
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(op_t'($urandom_range(0, 3)), pick_offset(), rand64());
            end
        end
    endtask

    // Main sequence: reset, directed checks, then random phases per setting.
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_NONE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values, a counter write read back, then writes and reads that must be ignored or read zero.
        send_item(OP_READ, OFS_ID, '0);
        send_item(OP_READ, OFS_T0CONFIG, '0);
        send_item(OP_READ, OFS_T0COMP, '0);
        send_item(OP_READ, OFS_GCONFIG, '0);
        send_item(OP_TICK, OFS_ID, '1);
        send_item(OP_WRITE, OFS_COUNTER, 64'hFFFF_FFFF_FFFF_FFFD);
        send_item(OP_READ, OFS_COUNTER, '0);
        send_item(OP_WRITE, OFS_ID, '1);
        send_item(OP_READ, 9'h011, '1);
        send_item(OP_WRITE, 9'h111, '1);
        send_item(OP_READ, OFS_T0ROUTE, '0);
        send_item(OP_NONE, OFS_COUNTER, '1);

        // Legacy firing at the top of the count, and status clearing.
        send_item(OP_WRITE, OFS_T0CONFIG, 64'h4);
        send_item(OP_WRITE, OFS_GCONFIG, 64'h3);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '1, '1);
        send_item(OP_READ, OFS_STATUS, '0);
        send_item(OP_WRITE, OFS_STATUS, 64'h0);
        send_item(OP_WRITE, OFS_STATUS, 64'h1);

        // Message firing as the counter wraps to zero.
        send_item(OP_WRITE, OFS_T0ROUTE, '1);
        send_item(OP_WRITE, OFS_T0CONFIG, 64'h4004);
        send_item(OP_WRITE, OFS_T0COMP, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_READ, OFS_T0CONFIG, '0);
        send_item(OP_READ, 9'h1FF, '0);

        // Long receiver hold-off while the sender keeps offering back to back.
        hold_requests++;
        steady = 1'b1;
        repeat (40)
            send_item(op_t'($urandom_range(0, 1)), pick_offset(), rand64());
        steady = 1'b0;
        run_random(85);

        for (int ph = 1; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                1: begin
                    apb_write(CFG_PERIOD, 32'd1);
                    apb_write(CFG_MSGCAP, 32'd0);
                end
                2: begin
                    apb_write(CFG_PERIOD, 32'd100000000);
                    apb_write(CFG_MSGCAP, 32'd1);
                end
                default: begin
                    apb_write(CFG_PERIOD, 32'($urandom_range(1, 100000000)));
                    apb_write(CFG_MSGCAP, 32'($urandom_range(0, 1)));
                end
            endcase
            run_random(85);
        end

        wait_idle();
        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
